>>> rtl/accel_tilt_angles_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tilt angle block
// Concurrent assertion shorthands with a clock, an active-low reset and a message.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLES_ASSERT_SVH
`define ACCEL_TILT_ANGLES_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATA_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/atilt_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle package
// Widths, angle constants and the arctangent table of the CORDIC pipeline.
// ----------------------------------------------------------------------------
package atilt_pkg;

    // Default number of CORDIC micro-rotations.
    localparam int unsigned CORDIC_ITER_DEF = 16;
    // Nominal length of the arctangent table; atan_lut gives nonzero entries for steps 0 to 21 only.
    localparam int unsigned ATAN_LEN = 24;

    // Vector components: raw counts in Q16, with headroom for the CORDIC gain.
    localparam int unsigned VEC_W = 36;
    // Angle accumulator in 1/256 centidegree.
    localparam int unsigned ANG_W = 26;
    // Square root: radicand width and number of result bits.
    localparam int unsigned RAD_W = 64;
    localparam int unsigned SQRT_STEPS = 32;

    localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(2304000);
    localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(4608000);

    localparam logic signed [16:0] ROLL_LIM = 17'sd18000;
    localparam logic signed [16:0] PITCH_LIM = 17'sd9000;

    // State of one angle on its way through the rotation stages.
    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ANG_W-1:0] ang;
        logic                    hold;
    } cordic_t;

    // atan(2^-i) in 1/256 centidegree, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_lut(input int unsigned i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            0:       v = ANG_W'(1152000);
            1:       v = ANG_W'(680065);
            2:       v = ANG_W'(359328);
            3:       v = ANG_W'(182400);
            4:       v = ANG_W'(91554);
            5:       v = ANG_W'(45822);
            6:       v = ANG_W'(22916);
            7:       v = ANG_W'(11459);
            8:       v = ANG_W'(5730);
            9:       v = ANG_W'(2865);
            10:      v = ANG_W'(1432);
            11:      v = ANG_W'(716);
            12:      v = ANG_W'(358);
            13:      v = ANG_W'(179);
            14:      v = ANG_W'(90);
            15:      v = ANG_W'(45);
            16:      v = ANG_W'(22);
            17:      v = ANG_W'(11);
            18:      v = ANG_W'(6);
            19:      v = ANG_W'(3);
            20:      v = ANG_W'(1);
            21:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// Accelerometer tilt angles
// Roll and pitch in centidegrees from one raw sample, fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// One sample beat in gives one angle beat out. The pipeline takes a new sample
// every cycle while the output is not stalled. Its stages in order are the squares,
// their sum, the bit-per-stage square root of x^2 + z^2, a fold of the vectors
// into the right half-plane, the CORDIC micro-rotations, each in its own stage,
// and a round and clamp. The whole pipeline holds while a result waits on the
// output, so nothing is dropped.
`include "accel_tilt_angles_assert.svh"

module accel_tilt_angles #(
    parameter int unsigned CORDIC_ITERATIONS = atilt_pkg::CORDIC_ITER_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: accel_x[15:0], accel_y[31:16], accel_z[47:32].
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: roll_centideg[15:0], pitch_centideg[30:16], zero pad.
    output logic [31:0] m_tdata
);

    localparam int unsigned N = CORDIC_ITERATIONS;
    localparam int unsigned VW = atilt_pkg::VEC_W;
    localparam int unsigned AW = atilt_pkg::ANG_W;
    localparam int unsigned RW = atilt_pkg::RAD_W;
    localparam int unsigned SQ = atilt_pkg::SQRT_STEPS;
    localparam int unsigned DEPTH = SQ + N + 4;

    // Folds a vector into the right half-plane and settles the axis cases.
    function automatic atilt_pkg::cordic_t prep(input logic signed [VW-1:0] vx,
                                                input logic signed [VW-1:0] vy);
        atilt_pkg::cordic_t c;
        c.vx = vx;
        c.vy = vy;
        c.ang = '0;
        c.hold = 1'b0;
        priority if (vy == '0) begin
            c.ang = vx[VW-1] ? atilt_pkg::ANG_180 : '0;
            c.hold = 1'b1;
        end else if (vx == '0) begin
            c.ang = vy[VW-1] ? -atilt_pkg::ANG_90 : atilt_pkg::ANG_90;
            c.hold = 1'b1;
        end else if (vx[VW-1]) begin
            c.ang = vy[VW-1] ? -atilt_pkg::ANG_180 : atilt_pkg::ANG_180;
            c.vx = -vx;
            c.vy = -vy;
        end else begin
            // Right half-plane: the vector is rotated as it stands.
            c.hold = 1'b0;
        end
        return c;
    endfunction

    // Rounds to the nearest centidegree, ties away from zero, then clamps.
    function automatic logic signed [16:0] to_centi(input logic signed [AW-1:0] a,
                                                    input logic signed [16:0] lim);
        logic [AW-1:0] mag;
        logic [AW-1:0] rnd;
        logic signed [AW-1:0] c;
        mag = a[AW-1] ? AW'(-a) : AW'(a);
        rnd = (mag + AW'(128)) >> 8;
        c = a[AW-1] ? -$signed(rnd) : $signed(rnd);
        if (c > AW'(lim)) begin
            c = AW'(lim);
        end
        if (c < -AW'(lim)) begin
            c = -AW'(lim);
        end
        return c[16:0];
    endfunction

    logic adv;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    // The pipeline moves whenever the output slot is free or being taken.
    assign adv = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];
    assign vld_next = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Stage A: squares of x and z.
    logic [31:0] xx_reg, zz_reg;
    logic signed [15:0] xa_reg, ya_reg;
    // Stage B: radicand (x^2 + z^2) * 2^32.
    logic [RW-1:0] rad_reg;
    logic signed [15:0] xb_reg, yb_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx_reg <= 32'($signed(s_tdata[15:0]) * $signed(s_tdata[15:0]));
            zz_reg <= 32'($signed(s_tdata[47:32]) * $signed(s_tdata[47:32]));
            xa_reg <= s_tdata[15:0];
            ya_reg <= s_tdata[31:16];
            rad_reg <= {32'(xx_reg + zz_reg), 32'h0};
            xb_reg <= xa_reg;
            yb_reg <= ya_reg;
        end
    end

    // Square root, one result bit per stage.
    logic [RW-1:0] rem_reg [0:SQ];
    logic [RW-1:0] res_reg [0:SQ];
    logic signed [15:0] xs_reg [0:SQ];
    logic signed [15:0] ys_reg [0:SQ];

    assign rem_reg[0] = rad_reg;
    assign res_reg[0] = '0;
    assign xs_reg[0] = xb_reg;
    assign ys_reg[0] = yb_reg;

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (RW - 2 - 2 * k);
        logic [RW-1:0] trial;
        logic ge;
        logic [RW-1:0] rem_next, res_next;

        assign trial = res_reg[k] + BIT;
        assign ge = rem_reg[k] >= trial;
        assign rem_next = ge ? rem_reg[k] - trial : rem_reg[k];
        assign res_next = ge ? (res_reg[k] >> 1) + BIT : res_reg[k] >> 1;

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= rem_next;
                res_reg[k+1] <= res_next;
                xs_reg[k+1] <= xs_reg[k];
                ys_reg[k+1] <= ys_reg[k];
            end
        end
    end

    // Prep stage: roll is atan2(x, y), pitch is atan2(-y, r).
    logic signed [VW-1:0] x_q16, y_q16, r_q16;
    atilt_pkg::cordic_t roll_reg [0:N];
    atilt_pkg::cordic_t pitch_reg [0:N];

    assign x_q16 = $signed({{(VW-32){xs_reg[SQ][15]}}, xs_reg[SQ], 16'h0});
    assign y_q16 = $signed({{(VW-32){ys_reg[SQ][15]}}, ys_reg[SQ], 16'h0});
    assign r_q16 = $signed({1'b0, res_reg[SQ][VW-2:0]});

    always_ff @(posedge aclk) begin
        if (adv) begin
            roll_reg[0] <= prep(y_q16, x_q16);
            pitch_reg[0] <= prep(r_q16, -y_q16);
        end
    end

    // CORDIC micro-rotations in vectoring mode, one per stage.
    for (genvar i = 0; i < N; i++) begin : g_cordic
        localparam logic signed [AW-1:0] ATAN = atilt_pkg::atan_lut(i);
        atilt_pkg::cordic_t roll_next, pitch_next;

        always_comb begin
            roll_next = roll_reg[i];
            if (!roll_reg[i].hold) begin
                if (!roll_reg[i].vy[VW-1]) begin
                    roll_next.vx = roll_reg[i].vx + (roll_reg[i].vy >>> i);
                    roll_next.vy = roll_reg[i].vy - (roll_reg[i].vx >>> i);
                    roll_next.ang = roll_reg[i].ang + ATAN;
                end else begin
                    roll_next.vx = roll_reg[i].vx - (roll_reg[i].vy >>> i);
                    roll_next.vy = roll_reg[i].vy + (roll_reg[i].vx >>> i);
                    roll_next.ang = roll_reg[i].ang - ATAN;
                end
            end
        end

        always_comb begin
            pitch_next = pitch_reg[i];
            if (!pitch_reg[i].hold) begin
                if (!pitch_reg[i].vy[VW-1]) begin
                    pitch_next.vx = pitch_reg[i].vx + (pitch_reg[i].vy >>> i);
                    pitch_next.vy = pitch_reg[i].vy - (pitch_reg[i].vx >>> i);
                    pitch_next.ang = pitch_reg[i].ang + ATAN;
                end else begin
                    pitch_next.vx = pitch_reg[i].vx - (pitch_reg[i].vy >>> i);
                    pitch_next.vy = pitch_reg[i].vy + (pitch_reg[i].vx >>> i);
                    pitch_next.ang = pitch_reg[i].ang - ATAN;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                roll_reg[i+1] <= roll_next;
                pitch_reg[i+1] <= pitch_next;
            end
        end
    end

    // Output stage: round, clamp and pack.
    logic signed [16:0] roll_c, pitch_c;
    logic signed [15:0] roll_out_reg;
    logic signed [14:0] pitch_out_reg;

    assign roll_c = to_centi(roll_reg[N].ang, atilt_pkg::ROLL_LIM);
    assign pitch_c = to_centi(pitch_reg[N].ang, atilt_pkg::PITCH_LIM);

    always_ff @(posedge aclk) begin
        if (adv) begin
            roll_out_reg <= roll_c[15:0];
            pitch_out_reg <= pitch_c[14:0];
        end
    end

    assign m_tdata = {1'b0, pitch_out_reg, roll_out_reg};

    // Checks on the pipeline's own logic.
    `ATA_ASSERT_IMPL(a_roll_range, aclk, aresetn, m_tvalid,
        roll_out_reg >= -16'sd18000 && roll_out_reg <= 16'sd18000, "roll out of range")
    `ATA_ASSERT_IMPL(a_pitch_range, aclk, aresetn, m_tvalid,
        pitch_out_reg >= -15'sd9000 && pitch_out_reg <= 15'sd9000, "pitch out of range")
    `ATA_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready,
        vld_reg[0], "accepted beat did not enter the pipeline")
    `ATA_ASSERT_IMPL(a_sqrt_width, aclk, aresetn, vld_reg[SQ+1],
        res_reg[SQ][RW-1:32] == '0, "square root exceeds 32 bits")

endmodule
